// File: rtl/button_debounce_hold_click_top_macros.svh
// Assertion macros shared by the button qualifier RTL.
`ifndef BUTTON_DEBOUNCE_HOLD_CLICK_TOP_MACROS_SVH
`define BUTTON_DEBOUNCE_HOLD_CLICK_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge outside reset.
`define BDHC_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Check a property on every rising edge, reset included.
`define BDHC_ASSERT_ALWAYS(name, clk, prop, msg) \
	name: assert property (@(posedge clk) prop) \
		else $error(msg);

`else

`define BDHC_ASSERT(name, clk, rst_n, prop, msg)

`define BDHC_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

// File: rtl/bdhc_pkg.sv
// Types, codes and reset values for the button qualifier.
`default_nettype none

package bdhc_pkg;

	localparam int TIME_WIDTH_DEF = 32;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [31:0] DEBOUNCE_RST = 32'd50;
	localparam logic [31:0] HOLD_RST     = 32'd1000;
	localparam logic        INACTIVE_RST = 1'b1;

	// Register indexes (byte address bits [3:2])
	localparam logic [1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [1:0] REG_HOLD     = 2'd1;
	localparam logic [1:0] REG_INACTIVE = 2'd2;

	// Item operations
	localparam logic [1:0] OP_POLL    = 2'd0;
	localparam logic [1:0] OP_PRESS   = 2'd1;
	localparam logic [1:0] OP_CLICK   = 2'd2;
	localparam logic [1:0] OP_RELEASE = 2'd3;

	typedef enum logic [1:0] {
		IN_RELEASED = 2'd0,
		IN_DEBOUNCE = 2'd1,
		IN_PRESSED  = 2'd2,
		IN_HOLDING  = 2'd3
	} in_phase_t;

	typedef enum logic [2:0] {
		OUT_IDLE        = 3'd0,
		OUT_RELEASE     = 3'd1,
		OUT_PRESS       = 3'd2,
		OUT_CLICK_PRESS = 3'd3,
		OUT_CLICK_WAIT  = 3'd4
	} out_phase_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] now_time;
		logic        pin_level;
	} item_t;

	typedef struct packed {
		logic       command_accepted;
		logic       drive_write;
		logic       drive_level;
		logic       press_event;
		logic       hold_event;
		logic       release_event;
		logic       click_event;
		logic [1:0] button_state;
	} result_t;

	typedef struct packed {
		logic [31:0] settle_ticks;
		logic [31:0] long_press_ticks;
		logic        inactive_level;
	} cfg_t;

endpackage

`default_nettype wire

// File: rtl/bdhc_cfg.sv
// Configuration registers behind the APB-style port.
`default_nettype none

module bdhc_cfg (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [bdhc_pkg::ADDR_W-1:0] paddr,
	input  wire logic [bdhc_pkg::DATA_W-1:0] pwdata,
	output logic      [bdhc_pkg::DATA_W-1:0] prdata,
	output logic                            pready,
	output bdhc_pkg::cfg_t                  cfg
);
	import bdhc_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.settle_ticks     <= DEBOUNCE_RST;
			cfg_q.long_press_ticks <= HOLD_RST;
			cfg_q.inactive_level   <= INACTIVE_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_DEBOUNCE: cfg_q.settle_ticks     <= pwdata;
				REG_HOLD:     cfg_q.long_press_ticks <= pwdata;
				REG_INACTIVE: cfg_q.inactive_level   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_DEBOUNCE: prdata = cfg_q.settle_ticks;
			REG_HOLD:     prdata = cfg_q.long_press_ticks;
			REG_INACTIVE: prdata = {{(DATA_W-1){1'b0}}, cfg_q.inactive_level};
			default:      prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: rtl/bdhc_core.sv
// Output drive machine and input qualifier machine, one item per cycle while adv is high.
`default_nettype none
`include "button_debounce_hold_click_top_macros.svh"

module bdhc_core #(
	parameter int TIME_WIDTH = bdhc_pkg::TIME_WIDTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              adv,
	input  bdhc_pkg::item_t        item,
	input  bdhc_pkg::cfg_t         cfg,
	output bdhc_pkg::result_t      result
);
	import bdhc_pkg::*;

	localparam int CMP_W = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

	in_phase_t               in_phase_q, in_phase_d;
	out_phase_t              out_phase_q, out_phase_d;
	logic [TIME_WIDTH-1:0]   in_mark_q, in_mark_d;
	logic [TIME_WIDTH-1:0]   out_mark_q, out_mark_d;
	logic                    drive_q, drive_d;

	logic [TIME_WIDTH-1:0]   now_t;
	logic [TIME_WIDTH-1:0]   mark_eff;
	logic [TIME_WIDTH-1:0]   in_elapsed;
	logic [TIME_WIDTH-1:0]   out_elapsed;
	logic                    deb_ok, hold_ok, click_done;
	logic                    pin_active;
	logic                    is_poll;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_phase_q  <= IN_RELEASED;
			out_phase_q <= OUT_IDLE;
			in_mark_q   <= '0;
			out_mark_q  <= '0;
			drive_q     <= 1'b0;
		end else if (adv) begin
			in_phase_q  <= in_phase_d;
			out_phase_q <= out_phase_d;
			in_mark_q   <= in_mark_d;
			out_mark_q  <= out_mark_d;
			drive_q     <= drive_d;
		end
	end

	// Elapsed times wrap modulo the timer width
	assign now_t       = TIME_WIDTH'(item.now_time);
	assign mark_eff    = (in_phase_q == IN_RELEASED) ? now_t : in_mark_q;
	assign in_elapsed  = now_t - mark_eff;
	assign out_elapsed = now_t - out_mark_q;
	assign deb_ok      = CMP_W'(in_elapsed) >= CMP_W'(cfg.settle_ticks);
	assign hold_ok     = (cfg.long_press_ticks != '0) &&
	                     (CMP_W'(in_elapsed) >= CMP_W'(cfg.long_press_ticks));
	assign click_done  = CMP_W'(out_elapsed) >= CMP_W'(cfg.settle_ticks);
	assign pin_active  = item.pin_level != cfg.inactive_level;
	assign is_poll     = item.operation == OP_POLL;

	always_comb begin
		in_phase_d  = in_phase_q;
		out_phase_d = out_phase_q;
		in_mark_d   = in_mark_q;
		out_mark_d  = out_mark_q;
		drive_d     = drive_q;
		result      = '0;

		case (item.operation)
			OP_PRESS, OP_CLICK: begin
				if (out_phase_q == OUT_IDLE) begin
					out_phase_d = (item.operation == OP_PRESS) ? OUT_PRESS : OUT_CLICK_PRESS;
					result.command_accepted = 1'b1;
				end
			end
			OP_RELEASE: begin
				if (out_phase_q == OUT_PRESS) begin
					out_phase_d = OUT_RELEASE;
					result.command_accepted = 1'b1;
				end
			end
			default: begin
				case (out_phase_q)
					OUT_CLICK_PRESS: begin
						out_phase_d = OUT_CLICK_WAIT;
						out_mark_d  = now_t;
						drive_d     = 1'b1;
						result.drive_write = 1'b1;
					end
					OUT_PRESS: begin
						drive_d = 1'b1;
						result.drive_write = 1'b1;
					end
					OUT_CLICK_WAIT: begin
						if (click_done)
							out_phase_d = OUT_RELEASE;
					end
					OUT_RELEASE: begin
						drive_d     = 1'b0;
						out_phase_d = OUT_IDLE;
						result.drive_write = 1'b1;
					end
					default: ;
				endcase

				if (!pin_active) begin
					result.release_event = (in_phase_q == IN_PRESSED) ||
					                       (in_phase_q == IN_HOLDING);
					result.click_event   = in_phase_q == IN_PRESSED;
					in_phase_d = IN_RELEASED;
				end else begin
					in_mark_d = mark_eff;
					// Press and hold may both land in the same tick
					case (in_phase_q)
						IN_RELEASED, IN_DEBOUNCE: begin
							if (deb_ok) begin
								result.press_event = 1'b1;
								if (hold_ok) begin
									result.hold_event = 1'b1;
									in_phase_d = IN_HOLDING;
								end else begin
									in_phase_d = IN_PRESSED;
								end
							end else begin
								in_phase_d = IN_DEBOUNCE;
							end
						end
						IN_PRESSED: begin
							if (hold_ok) begin
								result.hold_event = 1'b1;
								in_phase_d = IN_HOLDING;
							end
						end
						default: ;
					endcase
				end
			end
		endcase

		result.drive_level  = drive_d ? ~cfg.inactive_level : cfg.inactive_level;
		result.button_state = in_phase_d;
	end

	`BDHC_ASSERT(a_click_wait_drives, clk, arst_n,
		out_phase_q == OUT_CLICK_WAIT |-> drive_q,
		"click wait phase without active drive")
	`BDHC_ASSERT(a_idle_released, clk, arst_n,
		out_phase_q == OUT_IDLE |-> !drive_q,
		"idle output phase with active drive")
	`BDHC_ASSERT(a_cmd_keeps_drive, clk, arst_n,
		adv && !is_poll |=> drive_q == $past(drive_q),
		"command item changed the pin drive")

endmodule

`default_nettype wire

// File: rtl/button_debounce_hold_click_top.sv
// Top level of the button qualifier: input register, core logic, result register.
//
//   channel  direction  handshake                 payload
//   item     in         item_valid / item_stall   bdhc_pkg::item_t
//   result   out        result_valid / result_stall bdhc_pkg::result_t
//   config   in         APB-style psel/penable    32-bit registers at 0x0, 0x4, 0x8
//
// One item per clock while the result is not stalled. An accepted item sits in the
// input register while the core machines and three elapsed-time compares work out
// its result, which loads into the result register once the output is free;
// result_valid is registered alongside it.
// arst_n clears both phases, the time marks, the drive and all valid flags;
// configuration returns to its default values. There is no clearing pass.
// A stalled result holds the input register, and item_stall rises only when both
// registers are full.
`default_nettype none
`include "button_debounce_hold_click_top_macros.svh"

module button_debounce_hold_click_top #(
	parameter int TIME_WIDTH = bdhc_pkg::TIME_WIDTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       item_valid,
	output logic                            item_stall,
	input  bdhc_pkg::item_t                 item,
	output logic                            result_valid,
	input  wire logic                       result_stall,
	output bdhc_pkg::result_t               result,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [bdhc_pkg::ADDR_W-1:0] paddr,
	input  wire logic [bdhc_pkg::DATA_W-1:0] pwdata,
	output logic      [bdhc_pkg::DATA_W-1:0] prdata,
	output logic                            pready
);
	import bdhc_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_d;
	result_t res_q;
	logic    res_valid_q;
	logic    out_free;
	logic    adv;
	logic    take;

	assign out_free   = !res_valid_q || !result_stall;
	assign adv        = valid_s1 && out_free;
	assign item_stall = valid_s1 && !out_free;
	assign take       = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (take || adv)
			valid_s1 <= take;
	end

	always_ff @(posedge clk) begin
		if (take)
			item_s1 <= item;
	end

	bdhc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bdhc_core #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.result (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (out_free)
			res_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_q <= res_d;
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	`BDHC_ASSERT(a_click_has_release, clk, arst_n,
		result_valid && result.click_event |-> result.release_event,
		"click without release")
	`BDHC_ASSERT(a_hold_state, clk, arst_n,
		result_valid && result.hold_event |-> result.button_state == IN_HOLDING,
		"hold event outside holding phase")
	`BDHC_ASSERT(a_stall_full, clk, arst_n,
		item_stall |-> valid_s1 && res_valid_q && result_stall,
		"input stalled with room in the pipeline")
	`BDHC_ASSERT_ALWAYS(a_reset_empty, clk,
		!arst_n |=> !result_valid && !valid_s1,
		"valid flags not cleared by reset")

endmodule

`default_nettype wire
